### src/plk_pkg.sv
// Shared types and constants for the peer link session keepalive block.
package plk_pkg;

    localparam logic [1:0] KIND_POLL  = 2'd0;
    localparam logic [1:0] KIND_FRAME = 2'd1;
    localparam logic [1:0] KIND_DOWN  = 2'd2;

    localparam logic [7:0] MSG_HELLO     = 8'd1;
    localparam logic [7:0] MSG_HELLO_ACK = 8'd2;
    localparam logic [7:0] MSG_HEARTBEAT = 8'd3;
    localparam logic [7:0] MSG_TEST      = 8'd4;
    localparam logic [7:0] MSG_TEST_ACK  = 8'd5;

    localparam logic [2:0] TX_NONE = 3'd0;

    localparam logic [31:0] MAGIC_WORD    = 32'h524E_4731;
    localparam logic [7:0]  FRAME_VERSION = 8'd1;
    localparam logic [7:0]  FRAME_BYTES   = 8'd32;
    localparam logic [31:0] TEST_MIX      = 32'h1234_5678;

    localparam logic [2:0] CFG_LOCAL_SESSION = 3'd0;
    localparam logic [2:0] CFG_LOCAL_ROLE    = 3'd1;
    localparam logic [2:0] CFG_PEER_ROLE     = 3'd2;
    localparam logic [2:0] CFG_SEND_INTERVAL = 3'd3;
    localparam logic [2:0] CFG_RX_TIMEOUT    = 3'd4;

    localparam logic [63:0] RST_LOCAL_SESSION = 64'd1;
    localparam logic [7:0]  RST_LOCAL_ROLE    = 8'd0;
    localparam logic [7:0]  RST_PEER_ROLE     = 8'd1;
    localparam logic [15:0] RST_SEND_INTERVAL = 16'd1000;
    localparam logic [15:0] RST_RX_TIMEOUT    = 16'd3000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now_ms;
        logic        addr_ok;
        logic [31:0] magic;
        logic [7:0]  version;
        logic [7:0]  msg_type;
        logic [7:0]  role;
        logic [7:0]  size;
        logic [63:0] remote_session;
        logic [31:0] number;
        logic [63:0] target_session;
        logic [31:0] payload;
    } in_t;

    typedef struct packed {
        logic [2:0]  tx_type;
        logic [31:0] tx_seq;
        logic [63:0] tx_target;
        logic [31:0] tx_value;
        logic        link_online;
        logic [31:0] rx_count;
        logic [31:0] rejected_count;
        logic [31:0] test_ack_count;
        logic [31:0] test_timeout_count;
        logic [31:0] last_rtt_ms;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [63:0] local_session;
        logic [7:0]  local_role;
        logic [7:0]  peer_role;
        logic [15:0] send_interval;
        logic [15:0] rx_timeout;
    } cfg_t;

    typedef struct packed {
        logic two;
        out_t first;
        out_t second;
    } res_t;

endpackage

### src/plk_cfg.sv
// Configuration register file of the peer link block.
module plk_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_wdata,
    output plk_pkg::cfg_t       cfg
);

    plk_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.local_session <= plk_pkg::RST_LOCAL_SESSION;
            cfg_reg.local_role    <= plk_pkg::RST_LOCAL_ROLE;
            cfg_reg.peer_role     <= plk_pkg::RST_PEER_ROLE;
            cfg_reg.send_interval <= plk_pkg::RST_SEND_INTERVAL;
            cfg_reg.rx_timeout    <= plk_pkg::RST_RX_TIMEOUT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                plk_pkg::CFG_LOCAL_SESSION: cfg_reg.local_session <= cfg_wdata;
                plk_pkg::CFG_LOCAL_ROLE:    cfg_reg.local_role    <= cfg_wdata[7:0];
                plk_pkg::CFG_PEER_ROLE:     cfg_reg.peer_role     <= cfg_wdata[7:0];
                plk_pkg::CFG_SEND_INTERVAL: cfg_reg.send_interval <= cfg_wdata[15:0];
                plk_pkg::CFG_RX_TIMEOUT:    cfg_reg.rx_timeout    <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### src/plk_core.sv
// Session state registers and the single-pass step logic of the peer link block.
module plk_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  plk_pkg::in_t    item,
    input  plk_pkg::cfg_t   cfg,
    output plk_pkg::res_t   res
);

    logic [63:0] peer_sess_reg, peer_sess_next;
    logic [31:0] seq_counter_reg, seq_counter_next;
    logic [31:0] hello_seq_reg, hello_seq_next;
    logic [31:0] test_seq_reg, test_seq_next;
    logic [31:0] test_value_reg, test_value_next;
    logic [31:0] test_time_reg, test_time_next;
    logic [31:0] last_rx_reg, last_rx_next;
    logic [31:0] last_send_reg, last_send_next;
    logic [31:0] peer_last_seq_reg, peer_last_seq_next;
    logic        send_due_reg, send_due_next;
    logic        hello_pending_reg, hello_pending_next;
    logic        test_pending_reg, test_pending_next;
    logic        have_peer_seq_reg, have_peer_seq_next;
    logic        online_reg, online_next;
    logic [31:0] rx_cnt_reg, rx_cnt_next;
    logic [31:0] rej_cnt_reg, rej_cnt_next;
    logic [31:0] tack_cnt_reg, tack_cnt_next;
    logic [31:0] tto_cnt_reg, tto_cnt_next;
    logic [31:0] rtt_reg, rtt_next;

    logic [31:0] rx_age;
    logic [31:0] test_age;
    logic [31:0] send_age;
    logic [31:0] seq_gap;
    logic [31:0] seq_one;
    logic [31:0] seq_two;
    logic        hdr_ok;
    logic        accepted;
    logic        two;
    logic        one;
    logic [2:0]  tx0_type;
    logic [31:0] tx0_seq;
    logic [63:0] tx0_target;
    logic [31:0] tx0_value;
    logic [2:0]  tx1_type;
    logic [31:0] tx1_seq;
    logic [63:0] tx1_target;
    logic [31:0] tx1_value;

    assign rx_age   = item.now_ms - last_rx_reg;
    assign test_age = item.now_ms - test_time_reg;
    assign send_age = item.now_ms - last_send_reg;
    assign seq_gap  = item.number - peer_last_seq_reg;
    assign seq_one  = seq_counter_reg + 32'd1;
    assign seq_two  = seq_counter_reg + 32'd2;

    assign hdr_ok = item.addr_ok
        && (item.magic == plk_pkg::MAGIC_WORD)
        && (item.version == plk_pkg::FRAME_VERSION)
        && (item.role == cfg.peer_role)
        && (item.size == plk_pkg::FRAME_BYTES)
        && (item.remote_session != 64'd0)
        && (item.msg_type inside {[plk_pkg::MSG_HELLO:plk_pkg::MSG_TEST_ACK]});

    always_comb
    begin
        peer_sess_next     = peer_sess_reg;
        seq_counter_next   = seq_counter_reg;
        hello_seq_next     = hello_seq_reg;
        test_seq_next      = test_seq_reg;
        test_value_next    = test_value_reg;
        test_time_next     = test_time_reg;
        last_rx_next       = last_rx_reg;
        last_send_next     = last_send_reg;
        peer_last_seq_next = peer_last_seq_reg;
        send_due_next      = send_due_reg;
        hello_pending_next = hello_pending_reg;
        test_pending_next  = test_pending_reg;
        have_peer_seq_next = have_peer_seq_reg;
        online_next        = online_reg;
        rx_cnt_next        = rx_cnt_reg;
        rej_cnt_next       = rej_cnt_reg;
        tack_cnt_next      = tack_cnt_reg;
        tto_cnt_next       = tto_cnt_reg;
        rtt_next           = rtt_reg;
        accepted   = 1'b0;
        one        = 1'b0;
        two        = 1'b0;
        tx0_type   = plk_pkg::TX_NONE;
        tx0_seq    = 32'd0;
        tx0_target = 64'd0;
        tx0_value  = 32'd0;
        tx1_type   = plk_pkg::TX_NONE;
        tx1_seq    = 32'd0;
        tx1_target = 64'd0;
        tx1_value  = 32'd0;

        case (item.kind)
            plk_pkg::KIND_POLL:
            begin
                if (online_reg && (rx_age >= {16'd0, cfg.rx_timeout}))
                begin
                    online_next        = 1'b0;
                    peer_sess_next     = 64'd0;
                    have_peer_seq_next = 1'b0;
                    hello_pending_next = 1'b0;
                    test_pending_next  = 1'b0;
                    send_due_next      = 1'b1;
                end
                if (test_pending_next && (test_age >= {16'd0, cfg.send_interval}))
                begin
                    test_pending_next = 1'b0;
                    tto_cnt_next      = tto_cnt_reg + 32'd1;
                end
                if (send_due_next || (send_age >= {16'd0, cfg.send_interval}))
                begin
                    send_due_next  = 1'b0;
                    last_send_next = item.now_ms;
                    if (!online_next)
                    begin
                        seq_counter_next   = seq_one;
                        hello_seq_next     = seq_one;
                        hello_pending_next = 1'b1;
                        one                = 1'b1;
                        tx0_type           = plk_pkg::MSG_HELLO[2:0];
                        tx0_seq            = seq_one;
                    end
                    else
                    begin
                        seq_counter_next  = seq_two;
                        test_seq_next     = seq_two;
                        test_value_next   = seq_two ^ plk_pkg::TEST_MIX;
                        test_time_next    = item.now_ms;
                        test_pending_next = 1'b1;
                        two               = 1'b1;
                        tx0_type          = plk_pkg::MSG_HEARTBEAT[2:0];
                        tx0_seq           = seq_one;
                        tx0_target        = peer_sess_reg;
                        tx1_type          = plk_pkg::MSG_TEST[2:0];
                        tx1_seq           = seq_two;
                        tx1_target        = peer_sess_reg;
                        tx1_value         = seq_two ^ plk_pkg::TEST_MIX;
                    end
                end
            end
            plk_pkg::KIND_FRAME:
            begin
                if (hdr_ok)
                begin
                    case (item.msg_type)
                        plk_pkg::MSG_HELLO:
                        begin
                            if ((item.target_session == 64'd0) && (item.payload == 32'd0))
                            begin
                                if (peer_sess_reg != item.remote_session)
                                begin
                                    online_next        = 1'b0;
                                    test_pending_next  = 1'b0;
                                    have_peer_seq_next = 1'b0;
                                    peer_sess_next     = item.remote_session;
                                    send_due_next      = 1'b1;
                                end
                                one        = 1'b1;
                                tx0_type   = plk_pkg::MSG_HELLO_ACK[2:0];
                                tx0_seq    = item.number;
                                tx0_target = item.remote_session;
                                accepted   = 1'b1;
                            end
                        end
                        plk_pkg::MSG_HELLO_ACK:
                        begin
                            if ((item.target_session == cfg.local_session) && hello_pending_reg
                                && (item.number == hello_seq_reg) && (item.payload == 32'd0))
                            begin
                                if (peer_sess_reg != item.remote_session)
                                begin
                                    have_peer_seq_next = 1'b0;
                                    test_pending_next  = 1'b0;
                                end
                                peer_sess_next     = item.remote_session;
                                hello_pending_next = 1'b0;
                                online_next        = 1'b1;
                                last_rx_next       = item.now_ms;
                                accepted           = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (online_reg && (item.remote_session == peer_sess_reg)
                                && (item.target_session == cfg.local_session))
                            begin
                                if (item.msg_type == plk_pkg::MSG_TEST_ACK)
                                begin
                                    if (test_pending_reg && (item.number == test_seq_reg)
                                        && (item.payload == test_value_reg))
                                    begin
                                        test_pending_next = 1'b0;
                                        tack_cnt_next     = tack_cnt_reg + 32'd1;
                                        rtt_next          = test_age;
                                        last_rx_next      = item.now_ms;
                                        accepted          = 1'b1;
                                    end
                                end
                                else if (!((item.msg_type == plk_pkg::MSG_HEARTBEAT)
                                    && (item.payload != 32'd0)))
                                begin
                                    if (item.msg_type == plk_pkg::MSG_TEST)
                                    begin
                                        one        = 1'b1;
                                        tx0_type   = plk_pkg::MSG_TEST_ACK[2:0];
                                        tx0_seq    = item.number;
                                        tx0_target = item.remote_session;
                                        tx0_value  = item.payload;
                                    end
                                    if (!(have_peer_seq_reg
                                        && ((seq_gap == 32'd0) || seq_gap[31])))
                                    begin
                                        peer_last_seq_next = item.number;
                                        have_peer_seq_next = 1'b1;
                                        last_rx_next       = item.now_ms;
                                        accepted           = 1'b1;
                                    end
                                end
                            end
                        end
                    endcase
                end
                if (accepted)
                begin
                    rx_cnt_next = rx_cnt_reg + 32'd1;
                end
                else
                begin
                    rej_cnt_next = rej_cnt_reg + 32'd1;
                end
            end
            plk_pkg::KIND_DOWN:
            begin
                online_next        = 1'b0;
                peer_sess_next     = 64'd0;
                have_peer_seq_next = 1'b0;
                hello_pending_next = 1'b0;
                test_pending_next  = 1'b0;
                send_due_next      = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peer_sess_reg     <= 64'd0;
            seq_counter_reg   <= 32'd0;
            hello_seq_reg     <= 32'd0;
            test_seq_reg      <= 32'd0;
            test_value_reg    <= 32'd0;
            test_time_reg     <= 32'd0;
            last_rx_reg       <= 32'd0;
            last_send_reg     <= 32'd0;
            peer_last_seq_reg <= 32'd0;
            send_due_reg      <= 1'b1;
            hello_pending_reg <= 1'b0;
            test_pending_reg  <= 1'b0;
            have_peer_seq_reg <= 1'b0;
            online_reg        <= 1'b0;
            rx_cnt_reg        <= 32'd0;
            rej_cnt_reg       <= 32'd0;
            tack_cnt_reg      <= 32'd0;
            tto_cnt_reg       <= 32'd0;
            rtt_reg           <= 32'd0;
        end
        else if (step)
        begin
            peer_sess_reg     <= peer_sess_next;
            seq_counter_reg   <= seq_counter_next;
            hello_seq_reg     <= hello_seq_next;
            test_seq_reg      <= test_seq_next;
            test_value_reg    <= test_value_next;
            test_time_reg     <= test_time_next;
            last_rx_reg       <= last_rx_next;
            last_send_reg     <= last_send_next;
            peer_last_seq_reg <= peer_last_seq_next;
            send_due_reg      <= send_due_next;
            hello_pending_reg <= hello_pending_next;
            test_pending_reg  <= test_pending_next;
            have_peer_seq_reg <= have_peer_seq_next;
            online_reg        <= online_next;
            rx_cnt_reg        <= rx_cnt_next;
            rej_cnt_reg       <= rej_cnt_next;
            tack_cnt_reg      <= tack_cnt_next;
            tto_cnt_reg       <= tto_cnt_next;
            rtt_reg           <= rtt_next;
        end
    end

    always_comb
    begin
        res.two                       = two;
        res.first.tx_type             = tx0_type;
        res.first.tx_seq              = tx0_seq;
        res.first.tx_target           = tx0_target;
        res.first.tx_value            = tx0_value;
        res.first.link_online         = online_next;
        res.first.rx_count            = rx_cnt_next;
        res.first.rejected_count      = rej_cnt_next;
        res.first.test_ack_count      = tack_cnt_next;
        res.first.test_timeout_count  = tto_cnt_next;
        res.first.last_rtt_ms         = rtt_next;
        res.first.last                = !two || one;
        res.second.tx_type            = tx1_type;
        res.second.tx_seq             = tx1_seq;
        res.second.tx_target          = tx1_target;
        res.second.tx_value           = tx1_value;
        res.second.link_online        = online_next;
        res.second.rx_count           = rx_cnt_next;
        res.second.rejected_count     = rej_cnt_next;
        res.second.test_ack_count     = tack_cnt_next;
        res.second.test_timeout_count = tto_cnt_next;
        res.second.last_rtt_ms        = rtt_next;
        res.second.last               = 1'b1;
    end

endmodule

### src/plk_obuf.sv
// Two-entry result buffer that drives the output channel of the peer link block.
module plk_obuf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  plk_pkg::res_t   res,
    output logic            can_take,
    output logic            out_valid,
    input  logic            out_ready,
    output plk_pkg::out_t   out_data
);

    plk_pkg::out_t head_reg;
    plk_pkg::out_t tail_reg;
    logic [1:0]    cnt_reg;
    logic          pop;

    assign pop       = (cnt_reg != 2'd0) && out_ready;
    assign can_take  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (push)
        begin
            cnt_reg <= res.two ? 2'd2 : 2'd1;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            head_reg <= res.first;
            tail_reg <= res.second;
        end
        else if (pop)
        begin
            head_reg <= tail_reg;
        end
    end

endmodule

### src/peer_link_session_keepalive.sv
// Peer link session keepalive: input register, single-pass step logic, result buffer.
// Each input waits in the input register until the buffer can take its results.
// Throughput: one input per cycle while out_ready is high and it yields one result;
// a poll sending heartbeat and test yields two and stalls until the first is taken.
// Reset: asynchronous active-low; session state, counters and configuration take
// their reset values and both channels come up empty.
module peer_link_session_keepalive (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  plk_pkg::in_t    in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output plk_pkg::out_t   out_data,
    input  logic            cfg_we,
    input  logic [2:0]      cfg_index,
    input  logic [63:0]     cfg_wdata
);

    plk_pkg::in_t  item_reg;
    logic          item_vld_reg;
    plk_pkg::cfg_t cfg;
    plk_pkg::res_t res;
    logic          can_take;
    logic          step;

    assign step     = item_vld_reg && can_take;
    assign in_ready = !item_vld_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_data;
        end
    end

    plk_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    plk_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    plk_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .res       (res),
        .can_take  (can_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### bench/testbench.sv
// Testbench for the peer link session keepalive block with a behavioral link model.
`timescale 1ns / 100ps

module testbench;

    localparam logic [1:0]  KIND_UNUSED = 2'd3;
    localparam logic [31:0] SEQ_HALF    = 32'h8000_0000;
    localparam int          CYCLE_LIMIT = 600000;

    logic          clk;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    plk_pkg::in_t  in_data = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    plk_pkg::out_t out_data;
    logic          cfg_we = 1'b0;
    logic [2:0]    cfg_index = plk_pkg::CFG_LOCAL_SESSION;
    logic [63:0]   cfg_wdata = '0;

    peer_link_session_keepalive u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    plk_pkg::cfg_t cfg_model;
    logic [63:0] m_peer_session;
    logic [31:0] m_seq;
    logic [31:0] m_hello_seq;
    logic [31:0] m_test_seq;
    logic [31:0] m_test_value;
    logic [31:0] m_test_time;
    logic [31:0] m_rx_time;
    logic [31:0] m_send_time;
    logic [31:0] m_peer_seq;
    logic        m_send_due;
    logic        m_hello_wait;
    logic        m_test_wait;
    logic        m_peer_seq_known;
    logic        m_online;
    logic [31:0] m_rx_count;
    logic [31:0] m_rej_count;
    logic [31:0] m_ack_count;
    logic [31:0] m_timeout_count;
    logic [31:0] m_rtt;

    plk_pkg::out_t link_sends[$];
    plk_pkg::out_t expected_results[$];
    plk_pkg::out_t want_result;

    logic [31:0] ms_now = '0;
    logic [63:0] peer_id;
    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    int          hold_request = 0;
    int          fail_count = 0;
    int          cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void link_model_reset();
        cfg_model.local_session = plk_pkg::RST_LOCAL_SESSION;
        cfg_model.local_role    = plk_pkg::RST_LOCAL_ROLE;
        cfg_model.peer_role     = plk_pkg::RST_PEER_ROLE;
        cfg_model.send_interval = plk_pkg::RST_SEND_INTERVAL;
        cfg_model.rx_timeout    = plk_pkg::RST_RX_TIMEOUT;
        m_peer_session   = '0;
        m_seq            = '0;
        m_hello_seq      = '0;
        m_test_seq       = '0;
        m_test_value     = '0;
        m_test_time      = '0;
        m_rx_time        = '0;
        m_send_time      = '0;
        m_peer_seq       = '0;
        m_send_due       = 1'b1;
        m_hello_wait     = 1'b0;
        m_test_wait      = 1'b0;
        m_peer_seq_known = 1'b0;
        m_online         = 1'b0;
        m_rx_count       = '0;
        m_rej_count      = '0;
        m_ack_count      = '0;
        m_timeout_count  = '0;
        m_rtt            = '0;
    endfunction

    function automatic void link_send(logic [7:0] t, logic [31:0] s, logic [63:0] g,
                                      logic [31:0] v);
        plk_pkg::out_t o;
        o = '0;
        o.tx_type   = t[2:0];
        o.tx_seq    = s;
        o.tx_target = g;
        o.tx_value  = v;
        if (link_sends.size() < 2)
            link_sends.push_back(o);
    endfunction

    function automatic void link_drop();
        m_online         = 1'b0;
        m_peer_session   = '0;
        m_peer_seq_known = 1'b0;
        m_hello_wait     = 1'b0;
        m_test_wait      = 1'b0;
        m_send_due       = 1'b1;
    endfunction

    function automatic void link_poll(logic [31:0] now);
        logic [31:0] since_rx;
        logic [31:0] since_test;
        logic [31:0] since_send;
        since_rx   = now - m_rx_time;
        since_test = now - m_test_time;
        since_send = now - m_send_time;
        if (m_online && since_rx >= {16'd0, cfg_model.rx_timeout})
            link_drop();
        if (m_test_wait && since_test >= {16'd0, cfg_model.send_interval})
        begin
            m_test_wait = 1'b0;
            m_timeout_count++;
        end
        if (!m_send_due && since_send < {16'd0, cfg_model.send_interval})
            return;
        m_send_due  = 1'b0;
        m_send_time = now;
        if (!m_online)
        begin
            m_seq++;
            m_hello_seq  = m_seq;
            m_hello_wait = 1'b1;
            link_send(plk_pkg::MSG_HELLO, m_hello_seq, '0, '0);
        end
        else
        begin
            m_seq++;
            link_send(plk_pkg::MSG_HEARTBEAT, m_seq, m_peer_session, '0);
            m_seq++;
            m_test_seq   = m_seq;
            m_test_value = m_seq ^ plk_pkg::TEST_MIX;
            m_test_time  = now;
            m_test_wait  = 1'b1;
            link_send(plk_pkg::MSG_TEST, m_test_seq, m_peer_session, m_test_value);
        end
    endfunction

    function automatic logic link_frame(plk_pkg::in_t f);
        logic [31:0] gap;
        gap = f.number - m_peer_seq;
        if (!f.addr_ok)
            return 1'b0;
        if (f.magic != plk_pkg::MAGIC_WORD || f.version != plk_pkg::FRAME_VERSION ||
            f.role != cfg_model.peer_role || f.size != plk_pkg::FRAME_BYTES ||
            f.remote_session == 64'd0 || f.msg_type < plk_pkg::MSG_HELLO ||
            f.msg_type > plk_pkg::MSG_TEST_ACK)
            return 1'b0;
        if (f.msg_type == plk_pkg::MSG_HELLO)
        begin
            if (f.target_session != 64'd0 || f.payload != 32'd0)
                return 1'b0;
            if (m_peer_session != f.remote_session)
            begin
                m_online         = 1'b0;
                m_test_wait      = 1'b0;
                m_peer_seq_known = 1'b0;
                m_peer_session   = f.remote_session;
                m_send_due       = 1'b1;
            end
            link_send(plk_pkg::MSG_HELLO_ACK, f.number, f.remote_session, '0);
            return 1'b1;
        end
        if (f.msg_type == plk_pkg::MSG_HELLO_ACK)
        begin
            if (f.target_session != cfg_model.local_session || !m_hello_wait ||
                f.number != m_hello_seq || f.payload != 32'd0)
                return 1'b0;
            if (m_peer_session != f.remote_session)
            begin
                m_peer_seq_known = 1'b0;
                m_test_wait      = 1'b0;
            end
            m_peer_session = f.remote_session;
            m_hello_wait   = 1'b0;
            m_online       = 1'b1;
            m_rx_time      = f.now_ms;
            return 1'b1;
        end
        if (!m_online || f.remote_session != m_peer_session ||
            f.target_session != cfg_model.local_session)
            return 1'b0;
        if (f.msg_type == plk_pkg::MSG_TEST_ACK)
        begin
            if (!m_test_wait || f.number != m_test_seq || f.payload != m_test_value)
                return 1'b0;
            m_test_wait = 1'b0;
            m_ack_count++;
            m_rtt = f.now_ms - m_test_time;
        end
        else
        begin
            if (f.msg_type == plk_pkg::MSG_HEARTBEAT && f.payload != 32'd0)
                return 1'b0;
            if (m_peer_seq_known && (gap == 32'd0 || gap >= SEQ_HALF))
            begin
                if (f.msg_type == plk_pkg::MSG_TEST)
                    link_send(plk_pkg::MSG_TEST_ACK, f.number, f.remote_session, f.payload);
                return 1'b0;
            end
            m_peer_seq       = f.number;
            m_peer_seq_known = 1'b1;
            if (f.msg_type == plk_pkg::MSG_TEST)
                link_send(plk_pkg::MSG_TEST_ACK, f.number, f.remote_session, f.payload);
        end
        m_rx_time = f.now_ms;
        return 1'b1;
    endfunction

    function automatic void link_step(plk_pkg::in_t it);
        int            n;
        plk_pkg::out_t o;
        link_sends.delete();
        case (it.kind)
            plk_pkg::KIND_POLL:  link_poll(it.now_ms);
            plk_pkg::KIND_FRAME:
                if (link_frame(it))
                    m_rx_count++;
                else
                    m_rej_count++;
            plk_pkg::KIND_DOWN:  link_drop();
            default:             ;
        endcase
        n = (link_sends.size() > 0) ? link_sends.size() : 1;
        for (int k = 0; k < n; k++)
        begin
            if (k < link_sends.size())
                o = link_sends[k];
            else
                o = '0;
            o.link_online        = m_online;
            o.rx_count           = m_rx_count;
            o.rejected_count     = m_rej_count;
            o.test_ack_count     = m_ack_count;
            o.test_timeout_count = m_timeout_count;
            o.last_rtt_ms        = m_rtt;
            o.last               = (k == n - 1);
            expected_results.push_back(o);
        end
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s expected %0h actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with no expected result pending");
                fail_count++;
            end
            else
            begin
                want_result = expected_results.pop_front();
                compare_field("tx_type", 64'(want_result.tx_type), 64'(out_data.tx_type));
                compare_field("tx_seq", 64'(want_result.tx_seq), 64'(out_data.tx_seq));
                compare_field("tx_target", want_result.tx_target, out_data.tx_target);
                compare_field("tx_value", 64'(want_result.tx_value), 64'(out_data.tx_value));
                compare_field("link_online", 64'(want_result.link_online),
                              64'(out_data.link_online));
                compare_field("rx_count", 64'(want_result.rx_count), 64'(out_data.rx_count));
                compare_field("rejected_count", 64'(want_result.rejected_count),
                              64'(out_data.rejected_count));
                compare_field("test_ack_count", 64'(want_result.test_ack_count),
                              64'(out_data.test_ack_count));
                compare_field("test_timeout_count", 64'(want_result.test_timeout_count),
                              64'(out_data.test_timeout_count));
                compare_field("last_rtt_ms", 64'(want_result.last_rtt_ms),
                              64'(out_data.last_rtt_ms));
                compare_field("last", 64'(want_result.last), 64'(out_data.last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
            end
            else if (stalls_on && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    task automatic send_item(input plk_pkg::in_t it);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        link_step(it);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            plk_pkg::CFG_LOCAL_SESSION: cfg_model.local_session = data;
            plk_pkg::CFG_LOCAL_ROLE:    cfg_model.local_role    = data[7:0];
            plk_pkg::CFG_PEER_ROLE:     cfg_model.peer_role     = data[7:0];
            plk_pkg::CFG_SEND_INTERVAL: cfg_model.send_interval = data[15:0];
            plk_pkg::CFG_RX_TIMEOUT:    cfg_model.rx_timeout    = data[15:0];
            default:                    ;
        endcase
    endtask

    task automatic apply_cfg(input plk_pkg::cfg_t c);
        logic [63:0] junk;
        wait_drained();
        junk = {$urandom(), $urandom()};
        write_reg(plk_pkg::CFG_LOCAL_SESSION, c.local_session);
        write_reg(plk_pkg::CFG_LOCAL_ROLE, {junk[63:8], c.local_role});
        write_reg(plk_pkg::CFG_PEER_ROLE, {junk[63:8], c.peer_role});
        write_reg(plk_pkg::CFG_SEND_INTERVAL, {junk[63:16], c.send_interval});
        write_reg(plk_pkg::CFG_RX_TIMEOUT, {junk[63:16], c.rx_timeout});
        cfg_we <= 1'b0;
    endtask

    function automatic plk_pkg::in_t random_item();
        plk_pkg::in_t it;
        it.kind           = 2'($urandom_range(0, 3));
        it.now_ms         = $urandom();
        it.addr_ok        = 1'($urandom_range(0, 1));
        it.magic          = $urandom();
        it.version        = 8'($urandom());
        it.msg_type       = 8'($urandom());
        it.role           = 8'($urandom());
        it.size           = 8'($urandom());
        it.remote_session = {$urandom(), $urandom()};
        it.number         = $urandom();
        it.target_session = {$urandom(), $urandom()};
        it.payload        = $urandom();
        return it;
    endfunction

    function automatic plk_pkg::in_t event_of(logic [1:0] k);
        plk_pkg::in_t it;
        it = random_item();
        it.kind   = k;
        it.now_ms = ms_now;
        return it;
    endfunction

    function automatic plk_pkg::in_t frame_of(logic [7:0] t, logic [31:0] num,
                                              logic [63:0] tgt, logic [31:0] val);
        plk_pkg::in_t it;
        it.kind           = plk_pkg::KIND_FRAME;
        it.now_ms         = ms_now;
        it.addr_ok        = 1'b1;
        it.magic          = plk_pkg::MAGIC_WORD;
        it.version        = plk_pkg::FRAME_VERSION;
        it.msg_type       = t;
        it.role           = cfg_model.peer_role;
        it.size           = plk_pkg::FRAME_BYTES;
        it.remote_session = peer_id;
        it.number         = num;
        it.target_session = tgt;
        it.payload        = val;
        return it;
    endfunction

    function automatic logic [31:0] peer_number(int sel);
        logic [31:0] base;
        base = m_peer_seq_known ? m_peer_seq : $urandom();
        case (sel)
            6:       return base;
            7:       return base + SEQ_HALF;
            8:       return base + (SEQ_HALF - 32'd1);
            9:       return base - $urandom_range(1, 100);
            default: return base + $urandom_range(1, 3);
        endcase
    endfunction

    task automatic advance_poll_time();
        int per;
        int tmo;
        per = int'(cfg_model.send_interval);
        tmo = int'(cfg_model.rx_timeout);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: ms_now += $urandom_range(0, per);
            5, 6, 7:       ms_now += $urandom_range(per, 2 * per);
            8:             ms_now += $urandom_range(tmo, tmo + per);
            default:       ms_now = $urandom();
        endcase
    endtask

    task automatic gen_random_item(output plk_pkg::in_t it);
        int          pick;
        int          sel;
        logic [63:0] own;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 9);
        own  = cfg_model.local_session;
        if (pick < 30)
        begin
            advance_poll_time();
            it = event_of(plk_pkg::KIND_POLL);
        end
        else
        begin
            ms_now += $urandom_range(0, 3);
            if (pick < 38)
            begin
                it = frame_of(plk_pkg::MSG_HELLO_ACK,
                              (m_hello_wait && sel < 8) ? m_hello_seq : $urandom(), own, '0);
            end
            else if (pick < 53)
            begin
                it = frame_of(plk_pkg::MSG_HEARTBEAT, peer_number(sel), own,
                              (sel == 5) ? $urandom() : 32'd0);
            end
            else if (pick < 63)
            begin
                it = frame_of(plk_pkg::MSG_TEST, peer_number(sel), own, $urandom());
            end
            else if (pick < 71)
            begin
                it = frame_of(plk_pkg::MSG_TEST_ACK, m_test_seq, own, m_test_value);
                if (sel == 7)
                    it.payload ^= 32'd1 << $urandom_range(0, 31);
                else if (sel > 7)
                    it.number = $urandom();
            end
            else if (pick < 76)
            begin
                if (sel < 3)
                    peer_id = {$urandom(), $urandom()} | 64'd1;
                it = frame_of(plk_pkg::MSG_HELLO, $urandom(), '0, '0);
            end
            else if (pick < 88)
            begin
                it = frame_of(plk_pkg::MSG_HEARTBEAT, peer_number(0), own, '0);
                case (sel)
                    0: it.addr_ok = 1'b0;
                    1: it.magic ^= 32'd1 << $urandom_range(0, 31);
                    2: it.version ^= 8'd1 << $urandom_range(0, 7);
                    3: it.role ^= 8'd1 << $urandom_range(0, 7);
                    4: it.size ^= 8'd1 << $urandom_range(0, 7);
                    5: it.remote_session = '0;
                    6: it.msg_type = ($urandom_range(0, 1) == 0) ? 8'd0 :
                                     8'($urandom_range(6, 255));
                    7: it.target_session ^= 64'd1 << $urandom_range(0, 63);
                    8: it.remote_session ^= 64'd1 << $urandom_range(0, 63);
                    default:
                    begin
                        it.msg_type       = plk_pkg::MSG_HELLO;
                        it.target_session = '0;
                        it.payload        = $urandom() | 32'd1;
                    end
                endcase
            end
            else if (pick < 95)
            begin
                it = event_of(plk_pkg::KIND_FRAME);
            end
            else if (pick < 98)
            begin
                it = event_of(plk_pkg::KIND_DOWN);
            end
            else
            begin
                it = random_item();
            end
        end
    endtask

    task automatic run_random(input int count);
        plk_pkg::in_t it;
        repeat (count)
        begin
            gen_random_item(it);
            send_item(it);
        end
    endtask

    task automatic test_directed();
        plk_pkg::in_t  it;
        logic [63:0]   own;
        plk_pkg::cfg_t c;
        c.local_session = {$urandom(), $urandom()} | 64'd1;
        c.local_role    = plk_pkg::RST_LOCAL_ROLE;
        c.peer_role     = plk_pkg::RST_PEER_ROLE;
        c.send_interval = plk_pkg::RST_SEND_INTERVAL;
        c.rx_timeout    = plk_pkg::RST_RX_TIMEOUT;
        apply_cfg(c);
        own = cfg_model.local_session;
        ms_now = 32'd0;
        send_item(event_of(plk_pkg::KIND_POLL));
        ms_now = 32'd10;
        send_item(event_of(plk_pkg::KIND_POLL));
        it = frame_of(plk_pkg::MSG_HELLO_ACK, m_hello_seq, own, '0);
        it.addr_ok = 1'b0;
        send_item(it);
        send_item(frame_of(plk_pkg::MSG_HELLO_ACK, m_hello_seq, own, '0));
        send_item(event_of(KIND_UNUSED));
        ms_now = 32'd1010;
        send_item(event_of(plk_pkg::KIND_POLL));
        ms_now = 32'd1050;
        send_item(frame_of(plk_pkg::MSG_TEST_ACK, m_test_seq, own, m_test_value));
        send_item(frame_of(plk_pkg::MSG_HEARTBEAT, 32'd100, own, '0));
        send_item(frame_of(plk_pkg::MSG_HEARTBEAT, 32'd100, own, '0));
        send_item(frame_of(plk_pkg::MSG_TEST, 32'd101, own, $urandom()));
        send_item(frame_of(plk_pkg::MSG_TEST, 32'd50, own, $urandom()));
        send_item(frame_of(plk_pkg::MSG_HEARTBEAT, 32'd102, own, 32'hFFFF_FFFF));
        ms_now = 32'd2020;
        send_item(event_of(plk_pkg::KIND_POLL));
        ms_now = 32'd3030;
        send_item(event_of(plk_pkg::KIND_POLL));
        it = frame_of(plk_pkg::MSG_HEARTBEAT, 32'd103, own, '0);
        it.magic = ~plk_pkg::MAGIC_WORD;
        send_item(it);
        it = frame_of(plk_pkg::MSG_HEARTBEAT, 32'd103, own, '0);
        it.version = 8'hFF;
        send_item(it);
        it = frame_of(plk_pkg::MSG_HEARTBEAT, 32'd103, own, '0);
        it.msg_type = 8'd0;
        send_item(it);
        it = frame_of(plk_pkg::MSG_HEARTBEAT, 32'd103, own, '0);
        it.msg_type = 8'd6;
        send_item(it);
        it = frame_of(plk_pkg::MSG_HEARTBEAT, 32'd103, own, '0);
        it.remote_session = '0;
        send_item(it);
        ms_now = 32'd8000;
        send_item(event_of(plk_pkg::KIND_POLL));
        peer_id = ~peer_id | 64'd1;
        send_item(frame_of(plk_pkg::MSG_HELLO, 32'hFFFF_FFFF, '0, '0));
        ms_now = 32'd8001;
        send_item(event_of(plk_pkg::KIND_POLL));
        send_item(event_of(plk_pkg::KIND_DOWN));
        ms_now = 32'd8002;
        send_item(event_of(plk_pkg::KIND_POLL));
    endtask

    task automatic test_zero_session();
        plk_pkg::cfg_t c;
        c.local_session = '0;
        c.local_role    = 8'hFF;
        c.peer_role     = 8'h00;
        c.send_interval = 16'd1;
        c.rx_timeout    = 16'd1;
        apply_cfg(c);
        ms_now += 32'd5;
        send_item(event_of(plk_pkg::KIND_POLL));
        send_item(frame_of(plk_pkg::MSG_HELLO_ACK, m_hello_seq, '0, '0));
        send_item(frame_of(plk_pkg::MSG_HEARTBEAT, 32'hFFFF_FFFF, '0, '0));
        send_item(frame_of(plk_pkg::MSG_HEARTBEAT, 32'd0, '0, '0));
        run_random(250);
    endtask

    task automatic test_extreme_config();
        plk_pkg::cfg_t c;
        c.local_session = '1;
        c.local_role    = 8'h00;
        c.peer_role     = 8'hFF;
        c.send_interval = 16'hFFFF;
        c.rx_timeout    = 16'hFFFF;
        apply_cfg(c);
        run_random(250);
    endtask

    task automatic test_backpressure();
        plk_pkg::cfg_t c;
        c.local_session = {$urandom(), $urandom()} | 64'd1;
        c.local_role    = 8'($urandom());
        c.peer_role     = 8'($urandom());
        c.send_interval = 16'd100;
        c.rx_timeout    = 16'd300;
        apply_cfg(c);
        gaps_on = 1'b0;
        hold_request = 400;
        run_random(60);
        gaps_on = 1'b1;
    endtask

    task automatic test_random_config();
        plk_pkg::cfg_t c;
        repeat (3)
        begin
            c.local_session = {$urandom(), $urandom()} | 64'd1;
            c.local_role    = 8'($urandom());
            c.peer_role     = 8'($urandom());
            c.send_interval = 16'($urandom_range(1, 3000));
            c.rx_timeout    = 16'($urandom_range(1, 9000));
            apply_cfg(c);
            run_random(150);
        end
    endtask

    task automatic test_no_idle();
        plk_pkg::cfg_t c;
        c.local_session = plk_pkg::RST_LOCAL_SESSION;
        c.local_role    = plk_pkg::RST_LOCAL_ROLE;
        c.peer_role     = plk_pkg::RST_PEER_ROLE;
        c.send_interval = plk_pkg::RST_SEND_INTERVAL;
        c.rx_timeout    = plk_pkg::RST_RX_TIMEOUT;
        apply_cfg(c);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_random(200);
    endtask

    initial
    begin
        link_model_reset();
        peer_id = {$urandom(), $urandom()} | 64'd1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_zero_session();
        test_extreme_config();
        test_backpressure();
        test_random_config();
        test_no_idle();
        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
